/* hw/rtl/ldpc_layered_offset_min_sum_row_macros.svh */
// Assertion macros shared by the check-row unit's checker.
`ifndef LDPC_LAYERED_OFFSET_MIN_SUM_ROW_MACROS_SVH
`define LDPC_LAYERED_OFFSET_MIN_SUM_ROW_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LOMSR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LOMSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/lomsr_pkg.sv */
// Shared types and constants of the min-sum check-row unit.
`timescale 1ns / 1ps
package lomsr_pkg;

    localparam int MAX_ROW_DEGREE = 32;
    localparam int LLR_WIDTH      = 16;
    localparam int MSG_WIDTH      = 15;
    localparam int MAG_WIDTH      = LLR_WIDTH - 1;
    localparam int CMAG_WIDTH     = 14;
    localparam int IDX_WIDTH      = $clog2(MAX_ROW_DEGREE);
    localparam int CNT_WIDTH      = $clog2(MAX_ROW_DEGREE + 1);

    localparam logic signed [LLR_WIDTH-1:0] LLR_MAX = {1'b0, {(LLR_WIDTH-1){1'b1}}};
    localparam logic [MAG_WIDTH-1:0]        MAG_MAX = {MAG_WIDTH{1'b1}};

    // Configuration register indexes
    localparam logic [1:0] CFG_SCALE_CODE    = 2'd0;
    localparam logic [1:0] CFG_OFFSET_VALUE  = 2'd1;
    localparam logic [1:0] CFG_MESSAGE_LIMIT = 2'd2;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_SCALE,
        ST_DRAIN
    } t_state;

    // Control bundle from the row controller to the cell chain
    typedef struct packed {
        logic                 load;
        logic [IDX_WIDTH-1:0] idx;
        logic                 shift;
    } t_chain_ctrl;

endpackage

/* hw/rtl/lomsr_cell.sv */
// One cell of the difference chain: holds one edge difference.
`timescale 1ns / 1ps
module lomsr_cell
    import lomsr_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic signed [LLR_WIDTH-1:0] i_load_data,
    input  logic                        i_shift,
    input  logic signed [LLR_WIDTH-1:0] i_next_data,
    output logic signed [LLR_WIDTH-1:0] o_data
);

    logic signed [LLR_WIDTH-1:0] r_data;

    // load from the input side, or take the upper neighbor's value on a shift
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_load_data;
        end else if (i_shift) begin
            r_data <= i_next_data;
        end
    end

    assign o_data = r_data;

endmodule

/* hw/rtl/lomsr_chain.sv */
// Row of difference cells; written by edge index, drained toward cell 0.
`timescale 1ns / 1ps
module lomsr_chain
    import lomsr_pkg::*;
(
    input  logic                        i_clk,
    input  t_chain_ctrl                 i_ctrl,
    input  logic signed [LLR_WIDTH-1:0] i_data,
    output logic signed [LLR_WIDTH-1:0] o_head
);

    logic signed [LLR_WIDTH-1:0] w_cell [MAX_ROW_DEGREE];

    genvar g;
    generate
        for (g = 0; g < MAX_ROW_DEGREE; g++) begin : g_cell
            logic signed [LLR_WIDTH-1:0] w_next;
            logic                        w_load;

            // top cell recirculates its own value
            if (g == MAX_ROW_DEGREE - 1) begin : g_top
                assign w_next = w_cell[g];
            end else begin : g_mid
                assign w_next = w_cell[g+1];
            end

            assign w_load = i_ctrl.load && (i_ctrl.idx == IDX_WIDTH'(g));

            lomsr_cell u_cell (
                .i_clk       (i_clk),
                .i_load      (w_load),
                .i_load_data (i_data),
                .i_shift     (i_ctrl.shift),
                .i_next_data (w_next),
                .o_data      (w_cell[g])
            );
        end
    endgenerate

    assign o_head = w_cell[0];

endmodule

/* hw/rtl/ldpc_layered_offset_min_sum_row.sv */
// Check-row unit of a layered offset-normalized min-sum LDPC decoder.
//
// Edges of a check row stream in at one per cycle; each edge's saturated
// difference (posterior minus old message) is written into a chain of 32
// cells while the two smallest magnitudes and the sign parity are tracked.
// The row closes on tlast or on a full chain. The unit then scales the
// minima (offset, shift-sum normalization, clamp) and drains the row out
// of the cell chain, one edge per cycle from cell 0 while the output is
// not stalled, emitting new message and new posterior in edge order with
// tlast on the final edge. Input is held off from row close until the last
// result has been transferred. Configuration writes are always taken and
// must only be issued while the unit is idle.
`timescale 1ns / 1ps
module ldpc_layered_offset_min_sum_row
    import lomsr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data,
    // edge input: [15:0] posterior_llr, [30:16] old_message, [31] zero
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    // results: [14:0] new_message, [30:15] new_posterior, [31] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    // configuration registers
    logic [3:0]            r_scale_code;
    logic [MAG_WIDTH-1:0]  r_offset_value;
    logic [CMAG_WIDTH-1:0] r_message_limit;

    // row state
    t_state                r_state, n_state;
    logic [CNT_WIDTH-1:0]  r_count;
    logic [CNT_WIDTH-1:0]  r_left;
    logic [MAG_WIDTH-1:0]  r_min, r_sec;
    logic                  r_par;
    logic [CMAG_WIDTH-1:0] r_c_small, r_c_second;

    // output register
    logic                        r_out_valid;
    logic signed [MSG_WIDTH-1:0] r_out_msg;
    logic signed [LLR_WIDTH-1:0] r_out_post;
    logic                        r_out_last;

    // handshake and control
    logic        w_in_xfer;
    logic        w_row_close;
    logic        w_out_free;
    logic        w_pop;
    logic        w_drain_done;
    t_chain_ctrl w_ctrl;

    // input datapath
    logic signed [LLR_WIDTH-1:0] w_post;
    logic signed [MSG_WIDTH-1:0] w_old;
    logic signed [LLR_WIDTH:0]   w_sub;
    logic signed [LLR_WIDTH-1:0] w_diff;
    logic [MAG_WIDTH-1:0]        w_mag;
    logic [MAG_WIDTH-1:0]        w_hi;

    // output datapath
    logic signed [LLR_WIDTH-1:0] w_head;
    logic [MAG_WIDTH-1:0]        w_head_mag;
    logic [CMAG_WIDTH-1:0]       w_sel_mag;
    logic                        w_neg;
    logic signed [MSG_WIDTH-1:0] w_msg;
    logic signed [LLR_WIDTH:0]   w_add;
    logic signed [LLR_WIDTH-1:0] w_np;

    // offset, shift-sum scaling (bypassed when code bit 3 is set), clamp to the message limit and floor at zero
    function automatic logic [CMAG_WIDTH-1:0] scale_mag(
        input logic [MAG_WIDTH-1:0]  minimum,
        input logic [MAG_WIDTH-1:0]  offset,
        input logic [3:0]            code,
        input logic [CMAG_WIDTH-1:0] limit
    );
        logic signed [LLR_WIDTH-1:0] v;
        logic signed [LLR_WIDTH+1:0] r;
        logic signed [LLR_WIDTH+1:0] lim;
        v   = $signed({1'b0, minimum}) - $signed({1'b0, offset});
        lim = $signed({{(LLR_WIDTH+2-CMAG_WIDTH){1'b0}}, limit});
        if (code[3]) begin
            r = (LLR_WIDTH+2)'(v);
        end else begin
            r = '0;
            if (code[0]) r = r + (LLR_WIDTH+2)'(v >>> 3);
            if (code[1]) r = r + (LLR_WIDTH+2)'(v >>> 2);
            if (code[2]) r = r + (LLR_WIDTH+2)'(v >>> 1);
        end
        if (r > lim) begin
            r = lim;
        end
        if (r < 0) begin
            r = '0;
        end
        return r[CMAG_WIDTH-1:0];
    endfunction

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_code    <= 4'd8;
            r_offset_value  <= '0;
            r_message_limit <= CMAG_WIDTH'(511);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SCALE_CODE:    r_scale_code    <= i_cfg_data[3:0];
                CFG_OFFSET_VALUE:  r_offset_value  <= i_cfg_data[MAG_WIDTH-1:0];
                CFG_MESSAGE_LIMIT: r_message_limit <= i_cfg_data[CMAG_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // saturated difference and its magnitude
    assign w_post = $signed(s_axis_tdata[LLR_WIDTH-1:0]);
    assign w_old  = $signed(s_axis_tdata[LLR_WIDTH+MSG_WIDTH-1:LLR_WIDTH]);
    assign w_sub  = (LLR_WIDTH+1)'(w_post) - (LLR_WIDTH+1)'(w_old);

    always_comb begin
        if (w_sub > (LLR_WIDTH+1)'(LLR_MAX)) begin
            w_diff = LLR_MAX;
        end else if (w_sub < -((LLR_WIDTH+1)'(LLR_MAX))) begin
            w_diff = -LLR_MAX;
        end else begin
            w_diff = w_sub[LLR_WIDTH-1:0];
        end
    end

    assign w_mag = w_diff[LLR_WIDTH-1] ? MAG_WIDTH'(-w_diff) : w_diff[MAG_WIDTH-1:0];
    assign w_hi  = (w_mag > r_min) ? w_mag : r_min;

    // handshake terms
    assign w_in_xfer    = s_axis_tvalid && s_axis_tready;
    assign w_row_close  = w_in_xfer &&
                          (s_axis_tlast || (r_count == CNT_WIDTH'(MAX_ROW_DEGREE - 1)));
    assign w_out_free   = !r_out_valid || m_axis_tready;
    assign w_pop        = (r_state == ST_DRAIN) && w_out_free && (r_left != '0);
    assign w_drain_done = (r_state == ST_DRAIN) && w_out_free && (r_left == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_COLLECT: if (w_row_close) n_state = ST_SCALE;
            ST_SCALE:   n_state = ST_DRAIN;
            ST_DRAIN:   if (w_drain_done) n_state = ST_COLLECT;
            default:    n_state = ST_COLLECT;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_ctrl.load   = 1'b0;
        w_ctrl.idx    = r_count[IDX_WIDTH-1:0];
        w_ctrl.shift  = 1'b0;
        case (r_state)
            ST_COLLECT: begin
                s_axis_tready = 1'b1;
                w_ctrl.load   = w_in_xfer;
            end
            ST_DRAIN: begin
                w_ctrl.shift = w_pop;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    // row accumulators and drain counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_left  <= '0;
            r_min   <= MAG_MAX;
            r_sec   <= MAG_MAX;
            r_par   <= 1'b0;
        end else if (w_in_xfer) begin
            r_count <= r_count + 1'b1;
            r_par   <= r_par ^ w_diff[LLR_WIDTH-1];
            if (w_mag < r_min) r_min <= w_mag;
            if (w_hi < r_sec) r_sec <= w_hi;
        end else if (r_state == ST_SCALE) begin
            r_left <= r_count;
        end else if (w_pop) begin
            r_left <= r_left - 1'b1;
        end else if (w_drain_done) begin
            r_count <= '0;
            r_min   <= MAG_MAX;
            r_sec   <= MAG_MAX;
            r_par   <= 1'b0;
        end
    end

    // scaled minima, taken once per row
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCALE) begin
            r_c_small  <= scale_mag(r_min, r_offset_value, r_scale_code, r_message_limit);
            r_c_second <= scale_mag(r_sec, r_offset_value, r_scale_code, r_message_limit);
        end
    end

    // difference store
    lomsr_chain u_chain (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_data (w_diff),
        .o_head (w_head)
    );

    // new message and posterior for the edge at the chain head
    assign w_head_mag = w_head[LLR_WIDTH-1] ? MAG_WIDTH'(-w_head) : w_head[MAG_WIDTH-1:0];
    assign w_sel_mag  = (w_head_mag == r_min) ? r_c_second : r_c_small;
    assign w_neg      = r_par ^ w_head[LLR_WIDTH-1];
    assign w_msg      = w_neg ? -$signed({1'b0, w_sel_mag}) : $signed({1'b0, w_sel_mag});
    assign w_add      = (LLR_WIDTH+1)'(w_head) + (LLR_WIDTH+1)'(w_msg);

    always_comb begin
        if (w_add > (LLR_WIDTH+1)'(LLR_MAX)) begin
            w_np = LLR_MAX;
        end else if (w_add < -((LLR_WIDTH+1)'(LLR_MAX))) begin
            w_np = -LLR_MAX;
        end else begin
            w_np = w_add[LLR_WIDTH-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out_msg  <= w_msg;
            r_out_post <= w_np;
            r_out_last <= (r_left == CNT_WIDTH'(1));
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_post, r_out_msg};
    assign m_axis_tlast  = r_out_last;

endmodule

/* hw/rtl/lomsr_checker.sv */
// Port-level checker for the check-row unit, bound to the top level.
`timescale 1ns / 1ps
`include "ldpc_layered_offset_min_sum_row_macros.svh"
module lomsr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // a stalled result holds its payload
    `LOMSR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
        "stalled result changed")

    // no edge is taken while a row is being drained
    `LOMSR_ASSERT_NOW(a_no_in_during_drain, i_clk, i_rst_n, m_axis_tvalid,
        !s_axis_tready, "input ready while results pending")

    // closing a row with tlast stops input the next cycle
    `LOMSR_ASSERT_NEXT(a_close_stalls, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready && s_axis_tlast,
        !s_axis_tready, "input ready right after row end")

    // message and posterior stay inside their symmetric ranges
    `LOMSR_ASSERT_NOW(a_out_range, i_clk, i_rst_n, m_axis_tvalid,
        (m_axis_tdata[14:0] != 15'h4000) && (m_axis_tdata[30:15] != 16'h8000),
        "result outside symmetric range")

endmodule

bind ldpc_layered_offset_min_sum_row lomsr_checker u_lomsr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
